FILE: src/p2b_pkg.sv
// Shared types, constants and helpers for the pixel to BGRA converter.
// No dependencies; used by p2b_yuv and pixel_to_bgra_converter.
package p2b_pkg;

  // Source format codes held in the mode register
  localparam int MODE_W = 2;
  localparam logic [MODE_W-1:0] MODE_YUV     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RGB     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PALETTE = 2'd2;

  // Request kinds carried on tuser
  localparam logic CMD_CONVERT       = 1'b0;
  localparam logic CMD_PALETTE_WRITE = 1'b1;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int BYTE_W  = 8;
  localparam int ENTRY_W = 3 * BYTE_W;   // red 23:16, green 15:8, blue 7:0

  localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Fixed point: offsets in 1/16 units, Q12 coefficients, 16 fraction bits out
  localparam int TERM_W = 13;            // signed luma / chroma term
  localparam int COEF_W = 15;            // signed Q12 coefficient
  localparam int PROD_W = TERM_W + COEF_W;
  localparam int SUM_W  = PROD_W;        // sums stay well inside this width

  localparam logic signed [TERM_W-1:0] LUMA_OFS   = 13'sd255;
  localparam logic signed [TERM_W-1:0] CHROMA_OFS = 13'sd2040;

  localparam logic signed [COEF_W-1:0] Q_Y  = 15'sd4769;
  localparam logic signed [COEF_W-1:0] Q_RV = 15'sd6536;
  localparam logic signed [COEF_W-1:0] Q_GU = 15'sd1605;
  localparam logic signed [COEF_W-1:0] Q_GV = 15'sd3330;
  localparam logic signed [COEF_W-1:0] Q_BU = 15'sd8262;

  localparam logic signed [SUM_W-1:0] MAX_SUM = 28'sd16711680;  // 255 << 16

  // Saturate a 16-fraction-bit sum to 0..255, truncating the fraction
  function automatic logic [BYTE_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
    logic [BYTE_W-1:0] res;
    begin
      if (sum < 0) begin
        res = '0;
      end else if (sum >= MAX_SUM) begin
        res = 8'hFF;
      end else begin
        res = sum[16 +: BYTE_W];
      end
      return res;
    end
  endfunction

endpackage

FILE: src/p2b_yuv.sv
// BT.601 limited-range YUV to RGB datapath: registered products, then sum and clamp.
// Depends on p2b_pkg.
module p2b_yuv (
  input  logic                        clk,
  input  logic                        load,     // product stage takes new operands
  input  logic [p2b_pkg::BYTE_W-1:0]  y_in,
  input  logic [p2b_pkg::BYTE_W-1:0]  u_in,
  input  logic [p2b_pkg::BYTE_W-1:0]  v_in,
  output logic [p2b_pkg::BYTE_W-1:0]  red,
  output logic [p2b_pkg::BYTE_W-1:0]  green,
  output logic [p2b_pkg::BYTE_W-1:0]  blue
);

  logic signed [p2b_pkg::TERM_W-1:0] ly, cu, cv;

  logic signed [p2b_pkg::PROD_W-1:0] p_y_r, p_rv_r, p_gu_r, p_gv_r, p_bu_r;
  logic signed [p2b_pkg::PROD_W-1:0] p_y_nxt, p_rv_nxt, p_gu_nxt, p_gv_nxt, p_bu_nxt;

  logic signed [p2b_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;

  // 16*x minus offset, all in 1/16 units
  assign ly = $signed({1'b0, y_in, 4'b0000}) - p2b_pkg::LUMA_OFS;
  assign cu = $signed({1'b0, u_in, 4'b0000}) - p2b_pkg::CHROMA_OFS;
  assign cv = $signed({1'b0, v_in, 4'b0000}) - p2b_pkg::CHROMA_OFS;

  always_comb begin
    p_y_nxt  = p2b_pkg::PROD_W'(ly * p2b_pkg::Q_Y);
    p_rv_nxt = p2b_pkg::PROD_W'(cv * p2b_pkg::Q_RV);
    p_gu_nxt = p2b_pkg::PROD_W'(cu * p2b_pkg::Q_GU);
    p_gv_nxt = p2b_pkg::PROD_W'(cv * p2b_pkg::Q_GV);
    p_bu_nxt = p2b_pkg::PROD_W'(cu * p2b_pkg::Q_BU);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_y_r  <= p_y_nxt;
      p_rv_r <= p_rv_nxt;
      p_gu_r <= p_gu_nxt;
      p_gv_r <= p_gv_nxt;
      p_bu_r <= p_bu_nxt;
    end
  end

  assign sum_r = p_y_r + p_rv_r;
  assign sum_g = p_y_r - p_gu_r - p_gv_r;
  assign sum_b = p_y_r + p_bu_r;

  assign red   = p2b_pkg::clamp_channel(sum_r);
  assign green = p2b_pkg::clamp_channel(sum_g);
  assign blue  = p2b_pkg::clamp_channel(sum_b);

endmodule

FILE: src/pixel_to_bgra_converter.sv
// Pixel to BGRA converter top level: stream in, palette memory, three-stage pipe.
// Depends on p2b_pkg and p2b_yuv.
//
// Usage notes
// - in_*: one request per handshake. tuser selects the kind: convert a pixel,
//   or load one palette entry (RGB bytes into entry entry_number).
// - Palette loads give no output; every convert request gives exactly one.
// - out_*: BGRA pixel, alpha always 0xFF, tlast copies the input tlast.
// - cfg_*: 2-bit source mode (YUV, RGB byte swap, paletted). Always ready;
//   write only while the pipe is empty.
// - Throughput: one request per clock while no stall holds in_tready low. A convert
//   request accepted on in_* is presented on out_* after passing the palette read /
//   input register, the product register and the output register.
// - A palette entry is read with a registered memory read at accept, so a
//   convert may directly follow the load of the entry it uses.
// - Stall: a held output back-pressures stage by stage; empty stages keep
//   filling, so in_tready drops only when all three stages hold data.
// - Reset clears the stage valids and sets YUV mode; palette contents are
//   undefined until loaded and there is no clearing pass.
module pixel_to_bgra_converter #(
  parameter int PALETTE_ENTRIES = p2b_pkg::PALETTE_ENTRIES_DEF  // 2..256
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // byte_first, byte_second, byte_third, entry_number
  input  logic        in_tuser,   // command
  input  logic        in_tlast,   // frame_end
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // blue, green, red, alpha
  output logic        out_tlast,  // last_pixel
  // Mode register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // pixel_mode
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [p2b_pkg::BYTE_W:0] PAL_LIMIT = (p2b_pkg::BYTE_W + 1)'(PALETTE_ENTRIES);

  // Input field split
  logic [p2b_pkg::BYTE_W-1:0] in_b1, in_b2, in_b3, in_entry;
  assign in_b1    = in_tdata[7:0];
  assign in_b2    = in_tdata[15:8];
  assign in_b3    = in_tdata[23:16];
  assign in_entry = in_tdata[31:24];

  logic in_accept;
  logic wr_ok, rd_ok;

  // Mode register
  logic [p2b_pkg::MODE_W-1:0] mode_r;

  // Pipeline valids and flow control
  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic s1_adv, s2_adv, out_adv;

  // Stage 1 payload
  logic [p2b_pkg::BYTE_W-1:0]  s1_b1_r, s1_b2_r, s1_b3_r;
  logic                        s1_last_r, s1_rd_ok_r;
  logic [p2b_pkg::MODE_W-1:0]  s1_mode_r;
  logic [p2b_pkg::ENTRY_W-1:0] pal_rd_r;

  // Stage 2 payload
  logic [p2b_pkg::BYTE_W-1:0]  s2_b1_r, s2_b2_r, s2_b3_r;
  logic                        s2_last_r, s2_rd_ok_r;
  logic [p2b_pkg::MODE_W-1:0]  s2_mode_r;
  logic [p2b_pkg::ENTRY_W-1:0] s2_pal_r;

  // Output register
  logic [p2b_pkg::BYTE_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [p2b_pkg::BYTE_W-1:0] out_red_nxt, out_green_nxt, out_blue_nxt;
  logic                       out_last_r;

  logic [p2b_pkg::BYTE_W-1:0] yuv_red, yuv_green, yuv_blue;

  // Palette memory, no reset
  logic [p2b_pkg::ENTRY_W-1:0] palette_mem [PALETTE_ENTRIES];

  // Each stage moves when the one after it is empty or moving
  assign out_adv   = !out_vld_r || out_tready;
  assign s2_adv    = !s2_vld_r  || out_adv;
  assign s1_adv    = !s1_vld_r  || s2_adv;
  assign in_tready = s1_adv;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign wr_ok = ({1'b0, in_entry} < PAL_LIMIT);
  assign rd_ok = ({1'b0, in_b1} < PAL_LIMIT);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= p2b_pkg::MODE_YUV;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
      if (s1_adv) begin
        s1_vld_r <= in_accept && (in_tuser == p2b_pkg::CMD_CONVERT);
      end
      if (s2_adv) begin
        s2_vld_r <= s1_vld_r;
      end
      if (out_adv) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // Palette write and registered read, both on the accept edge
  always_ff @(posedge clk) begin
    if (in_accept && (in_tuser == p2b_pkg::CMD_PALETTE_WRITE) && wr_ok) begin
      palette_mem[in_entry[IDX_W-1:0]] <= {in_b1, in_b2, in_b3};
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      pal_rd_r <= palette_mem[in_b1[IDX_W-1:0]];
    end
  end

  // Stage 1: capture request
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_b1_r    <= in_b1;
      s1_b2_r    <= in_b2;
      s1_b3_r    <= in_b3;
      s1_last_r  <= in_tlast;
      s1_rd_ok_r <= rd_ok;
      s1_mode_r  <= mode_r;
    end
  end

  // Stage 2: products (inside p2b_yuv) and the pass-through paths
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_b1_r    <= s1_b1_r;
      s2_b2_r    <= s1_b2_r;
      s2_b3_r    <= s1_b3_r;
      s2_last_r  <= s1_last_r;
      s2_rd_ok_r <= s1_rd_ok_r;
      s2_mode_r  <= s1_mode_r;
      s2_pal_r   <= pal_rd_r;
    end
  end

  p2b_yuv u_yuv (
    .clk   (clk),
    .load  (s2_adv),
    .y_in  (s1_b1_r),
    .u_in  (s1_b2_r),
    .v_in  (s1_b3_r),
    .red   (yuv_red),
    .green (yuv_green),
    .blue  (yuv_blue)
  );

  // Stage 3: source select into the output register
  always_comb begin
    out_red_nxt   = '0;
    out_green_nxt = '0;
    out_blue_nxt  = '0;
    unique case (s2_mode_r)
      p2b_pkg::MODE_YUV: begin
        out_red_nxt   = yuv_red;
        out_green_nxt = yuv_green;
        out_blue_nxt  = yuv_blue;
      end
      p2b_pkg::MODE_RGB: begin
        out_red_nxt   = s2_b1_r;
        out_green_nxt = s2_b2_r;
        out_blue_nxt  = s2_b3_r;
      end
      p2b_pkg::MODE_PALETTE: begin
        // index past the palette reads as black
        if (s2_rd_ok_r) begin
          out_red_nxt   = s2_pal_r[23:16];
          out_green_nxt = s2_pal_r[15:8];
          out_blue_nxt  = s2_pal_r[7:0];
        end
      end
      default: begin
        // unused mode code: black
        out_red_nxt   = '0;
        out_green_nxt = '0;
        out_blue_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_red_r   <= out_red_nxt;
      out_green_r <= out_green_nxt;
      out_blue_r  <= out_blue_nxt;
      out_last_r  <= s2_last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {p2b_pkg::ALPHA_OPAQUE, out_red_r, out_green_r, out_blue_r};
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // A palette load never occupies the pipe
  a_load_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_tuser == p2b_pkg::CMD_PALETTE_WRITE) |=> !s1_vld_r)
    else $error("palette load entered the pipeline");

  // A convert request always enters stage 1
  a_convert_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_tuser == p2b_pkg::CMD_CONVERT) |=> s1_vld_r)
    else $error("convert request lost at stage 1");

  // Stage 2 holds its item while the output is stalled
  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && out_vld_r && !out_tready |=> s2_vld_r && $stable(s2_mode_r))
    else $error("stage 2 item dropped under stall");

  // An empty first stage never refuses input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_tready)
    else $error("input refused with stage 1 empty");
`endif

endmodule
